FILE: rtl/irtx_pkg.sv
// Shared constants, types and the code word table of the infrared remote transmitter.
`default_nettype none

package irtx_pkg;

  localparam int CodeBits     = 32;
  localparam int WordWidth    = 32;
  localparam int BitsLeftW    = $clog2(CodeBits + 1);
  localparam int CmdWidth     = 8;
  localparam int RegIndexW    = 3;
  localparam int CfgDataW     = 6;
  localparam int InDataW      = 8;
  localparam int OutDataW     = 8;
  localparam int NumCodes     = 12;

  localparam logic [RegIndexW-1:0] REG_CARRIER_HIGH = 3'd0;
  localparam logic [RegIndexW-1:0] REG_CARRIER_LOW  = 3'd1;
  localparam logic [RegIndexW-1:0] REG_PERIODS      = 3'd2;
  localparam logic [RegIndexW-1:0] REG_LEADER_MARK  = 3'd3;
  localparam logic [RegIndexW-1:0] REG_LEADER_SPACE = 3'd4;
  localparam logic [RegIndexW-1:0] REG_ONE_SPACE    = 3'd5;
  localparam logic [RegIndexW-1:0] REG_ZERO_SPACE   = 3'd6;
  localparam logic [RegIndexW-1:0] REG_TRAILER_MARK = 3'd7;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SEND = 1'b1;

  typedef logic [WordWidth-1:0] code_word_t;

  typedef struct packed {
    logic [5:0] carrier_high;
    logic [5:0] carrier_low;
    logic [5:0] periods_per_unit;
    logic [4:0] leader_mark;
    logic [4:0] leader_space;
    logic [3:0] one_space;
    logic [3:0] zero_space;
    logic [3:0] trailer_mark;
  } cfg_t;

  typedef struct packed {
    logic ir_out;
    logic busy_res;
    logic accepted;
    logic rejected;
    logic frame_done;
  } res_t;

  function automatic code_word_t code_rom(input logic [3:0] idx);
    code_word_t word;
    unique case (idx)
      4'd0:    word = 32'h02FD807F;
      4'd1:    word = 32'h02FD40BF;
      4'd2:    word = 32'h02FDC03F;
      4'd3:    word = 32'h02FD20DF;
      4'd4:    word = 32'h02FDA05F;
      4'd5:    word = 32'h02FD609F;
      4'd6:    word = 32'h02FDE01F;
      4'd7:    word = 32'h02FD10EF;
      4'd8:    word = 32'h02FD906F;
      4'd9:    word = 32'h02FD50AF;
      4'd10:   word = 32'h02FDD02F;
      4'd11:   word = 32'h02FD30CF;
      default: word = '0;
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ir_remote_frame_transmitter.sv
// Top level of the infrared remote frame transmitter.
//
// Words arrive on the slave stream: s_tuser says whether a word is a one
// microsecond tick or a send request, and s_tdata carries the command byte of
// a send. Every accepted word yields exactly one result word on the master
// stream: the emitter level for that tick, the busy flag, the accepted and
// rejected flags of a send, and m_tlast on the tick that ends the trailer
// mark. Configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata and act from the next word, also mid-frame. A word is processed in
// the cycle it is accepted and its result is registered for the master side;
// one word per cycle is sustained while the receiver takes results. When the
// receiver stalls, one further result is held in a skid register and s_tready
// falls until the backlog drains, so nothing is dropped. Reset loads the
// default carrier and timing registers, empties both result registers and
// leaves the transmitter idle.
`default_nettype none

module ir_remote_frame_transmitter
  import irtx_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [InDataW-1:0]   s_tdata,   // [7:0] command
  input  wire logic                 s_tuser,   // [0] req_type
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OutDataW-1:0]       m_tdata,   // [0] ir_out, [1] busy_res,
                                               // [2] accepted, [3] rejected
  output logic                      m_tlast,   // frame_done
  input  wire logic                 cfg_we,
  input  wire logic [RegIndexW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0]  cfg_wdata
);

  cfg_t cfg;
  res_t eng_res;
  res_t out_res;
  logic fire;

  assign fire = s_tvalid && s_tready;

  irtx_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irtx_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (s_tuser),
    .command  (s_tdata[CmdWidth-1:0]),
    .cfg      (cfg),
    .res      (eng_res)
  );

  irtx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fire),
    .in_ready  (s_tready),
    .in_res    (eng_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {4'b0000, out_res.rejected, out_res.accepted, out_res.busy_res,
                    out_res.ir_out};
  assign m_tlast = out_res.frame_done;

endmodule

`default_nettype wire

FILE: rtl/irtx_cfg_regs.sv
// Configuration register bank of the infrared remote transmitter.
`default_nettype none

module irtx_cfg_regs
  import irtx_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [RegIndexW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0]  cfg_wdata,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_high     <= 6'd8;
      cfg.carrier_low      <= 6'd18;
      cfg.periods_per_unit <= 6'd23;
      cfg.leader_mark      <= 5'd15;
      cfg.leader_space     <= 5'd7;
      cfg.one_space        <= 4'd3;
      cfg.zero_space       <= 4'd1;
      cfg.trailer_mark     <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CARRIER_HIGH: cfg.carrier_high     <= cfg_wdata;
        REG_CARRIER_LOW:  cfg.carrier_low      <= cfg_wdata;
        REG_PERIODS:      cfg.periods_per_unit <= cfg_wdata;
        REG_LEADER_MARK:  cfg.leader_mark      <= cfg_wdata[4:0];
        REG_LEADER_SPACE: cfg.leader_space     <= cfg_wdata[4:0];
        REG_ONE_SPACE:    cfg.one_space        <= cfg_wdata[3:0];
        REG_ZERO_SPACE:   cfg.zero_space       <= cfg_wdata[3:0];
        REG_TRAILER_MARK: cfg.trailer_mark     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/irtx_engine.sv
// Frame sequencer: carrier, unit and bit counters with the per-word result logic.
`default_nettype none

module irtx_engine
  import irtx_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic                req_type,
  input  wire logic [CmdWidth-1:0] command,
  input  wire cfg_t                cfg,
  output res_t                     res
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_TRAIL_MARK = 3'd5
  } phase_t;

  phase_t               phase, phase_next;
  code_word_t           code_shift, code_shift_next;
  logic [BitsLeftW-1:0] bits_left, bits_left_next, bits_dec;
  logic [4:0]           unit_count, unit_count_next, unit_inc, units;
  logic [5:0]           period_count, period_count_next, period_inc;
  logic [6:0]           tick_count, tick_count_next, tick_inc, tick_limit;
  logic                 pin, is_mark, bad_code;
  logic [3:0]           rom_idx;

  assign is_mark = (phase == PH_LEAD_MARK) || (phase == PH_BIT_MARK) ||
                   (phase == PH_TRAIL_MARK);
  assign pin        = is_mark && (tick_count < {1'b0, cfg.carrier_high});
  assign tick_limit = {1'b0, cfg.carrier_high} + {1'b0, cfg.carrier_low};
  assign tick_inc   = tick_count + 7'd1;
  assign period_inc = period_count + 6'd1;
  assign unit_inc   = unit_count + 5'd1;
  assign bits_dec   = bits_left - BitsLeftW'(1);
  assign bad_code   = (command == '0) || (command > CmdWidth'(NumCodes));
  assign rom_idx    = command[3:0] - 4'd1;

  always_comb begin
    unique case (phase)
      PH_LEAD_MARK:  units = cfg.leader_mark;
      PH_LEAD_SPACE: units = cfg.leader_space;
      PH_BIT_SPACE:  units = code_shift[WordWidth-1] ? {1'b0, cfg.one_space}
                                                     : {1'b0, cfg.zero_space};
      PH_TRAIL_MARK: units = {1'b0, cfg.trailer_mark};
      default:       units = 5'd1;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    code_shift_next   = code_shift;
    bits_left_next    = bits_left;
    unit_count_next   = unit_count;
    period_count_next = period_count;
    tick_count_next   = tick_count;
    res.ir_out        = 1'b0;
    res.accepted      = 1'b0;
    res.rejected      = 1'b0;
    res.frame_done    = 1'b0;
    if (fire) begin
      if (req_type == REQ_TICK) begin
        if (phase != PH_IDLE) begin
          res.ir_out      = pin;
          tick_count_next = tick_inc;
          if (tick_inc >= tick_limit) begin
            tick_count_next   = '0;
            period_count_next = period_inc;
            if (period_inc >= cfg.periods_per_unit) begin
              period_count_next = '0;
              unit_count_next   = unit_inc;
              if (unit_inc >= units) begin
                unit_count_next = '0;
                unique case (phase)
                  PH_LEAD_MARK:  phase_next = PH_LEAD_SPACE;
                  PH_LEAD_SPACE: phase_next = PH_BIT_MARK;
                  PH_BIT_MARK:   phase_next = PH_BIT_SPACE;
                  PH_BIT_SPACE: begin
                    code_shift_next = code_shift << 1;
                    bits_left_next  = bits_dec;
                    phase_next      = (bits_dec == '0) ? PH_TRAIL_MARK : PH_BIT_MARK;
                  end
                  PH_TRAIL_MARK: begin
                    phase_next     = PH_IDLE;
                    res.frame_done = 1'b1;
                  end
                  default: phase_next = PH_IDLE;
                endcase
              end
            end
          end
        end
      end else begin
        if ((phase != PH_IDLE) || bad_code) begin
          res.rejected = 1'b1;
          res.ir_out   = pin;
        end else begin
          code_shift_next   = code_rom(rom_idx) << (WordWidth - CodeBits);
          bits_left_next    = BitsLeftW'(CodeBits);
          unit_count_next   = '0;
          period_count_next = '0;
          tick_count_next   = '0;
          phase_next        = PH_LEAD_MARK;
          res.accepted      = 1'b1;
          res.ir_out        = |cfg.carrier_high;
        end
      end
    end
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      code_shift   <= '0;
      bits_left    <= '0;
      unit_count   <= '0;
      period_count <= '0;
      tick_count   <= '0;
    end else begin
      phase        <= phase_next;
      code_shift   <= code_shift_next;
      bits_left    <= bits_left_next;
      unit_count   <= unit_count_next;
      period_count <= period_count_next;
      tick_count   <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/irtx_out_buf.sv
// Result register with a skid stage between the sequencer and the output stream.
`default_nettype none

module irtx_out_buf
  import irtx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire res_t in_res,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic skid_valid;
  res_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid && !skid_valid) begin
      skid_res <= in_res;
    end
  end

endmodule

`default_nettype wire
